### rtl/nfa_pkg.sv
// Package for the next-fit identifier allocator.
// Holds the request and result word types, operation and class codes and sizing constants.
// No dependencies; every other file imports it.
package nfa_pkg;

  localparam int WORD_BITS = 32;
  localparam int WORD_W    = 5;
  localparam int MAX_SLOTS = 4096;
  localparam int OFS_W     = 12;
  localparam int ROW_W_MAX = OFS_W - WORD_W;
  localparam int CNT_W     = 13;

  localparam int DEF_PROC_FIRST   = 0;
  localparam int DEF_PROC_SLOTS   = 256;
  localparam int DEF_THREAD_FIRST = 256;
  localparam int DEF_THREAD_SLOTS = 1024;

  localparam logic [1:0] KIND_ALLOC    = 2'd0;
  localparam logic [1:0] KIND_RELEASE  = 2'd1;
  localparam logic [1:0] KIND_CLASSIFY = 2'd2;

  localparam logic POOL_PROC   = 1'b0;
  localparam logic POOL_THREAD = 1'b1;

  localparam logic [1:0] CLASS_PROC    = 2'd0;
  localparam logic [1:0] CLASS_THREAD  = 2'd1;
  localparam logic [1:0] CLASS_INVALID = 2'd2;

  typedef struct packed {
    logic [1:0]  kind;
    logic        pool;
    logic [15:0] ident;
  } req_word_t;

  typedef struct packed {
    logic [15:0] granted_id;
    logic        exhausted;
    logic [1:0]  id_class;
  } rsp_word_t;

  function automatic logic [WORD_BITS-1:0] low_mask(input logic [WORD_W:0] n);
    logic [WORD_BITS-1:0] m;
    for (int i = 0; i < WORD_BITS; i++) begin
      m[i] = ((WORD_W+1)'(i) < n);
    end
    return m;
  endfunction

endpackage

### rtl/nfa_bitmap.sv
// Used-bitmap store for one identifier pool, organised as rows of bitmap words.
// Each row has a valid flag cleared at reset, so an unwritten row reads as all free.
// Depends on nfa_pkg.
module nfa_bitmap import nfa_pkg::*; #(
  parameter  int ROWS  = 8,
  localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 rd_en,
  input  logic [ROW_W-1:0]     rd_row,
  output logic [WORD_BITS-1:0] rd_word,
  input  logic                 wr_en,
  input  logic [ROW_W-1:0]     wr_row,
  input  logic [WORD_BITS-1:0] wr_word
);

  logic [WORD_BITS-1:0] mem [ROWS];
  logic [ROWS-1:0]      row_valid;
  logic [WORD_BITS-1:0] rd_data;
  logic                 rd_valid;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_row] <= wr_word;
    end
    if (rd_en) begin
      rd_data <= mem[rd_row];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
      rd_valid  <= 1'b0;
    end else begin
      if (wr_en) begin
        row_valid[wr_row] <= 1'b1;
      end
      if (rd_en) begin
        rd_valid <= row_valid[rd_row];
      end
    end
  end

  assign rd_word = rd_valid ? rd_data : '0;

endmodule

### rtl/nfa_ffz.sv
// Shared search unit: finds the lowest free bit of a bitmap word at or above a start position.
// Used by both pools in turn under the top-level sequencer.
// Depends on nfa_pkg.
module nfa_ffz import nfa_pkg::*; (
  input  logic [WORD_BITS-1:0] word,
  input  logic [WORD_W-1:0]    from,
  output logic                 found,
  output logic [WORD_W-1:0]    pos
);

  logic [WORD_BITS-1:0] free;

  always_comb begin
    free  = ~word & ({WORD_BITS{1'b1}} << from);
    found = |free;
    pos   = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (free[i]) begin
        pos = WORD_W'(i);
      end
    end
  end

endmodule

### rtl/next_fit_id_allocator_top.sv
// Next-fit identifier allocator with a process pool and a thread pool; top level and sequencer.
// Depends on nfa_pkg, nfa_bitmap and nfa_ffz.
//
// One request word is taken at a time and yields one result word. Classify, and an allocate
// from a full pool, go straight to the push state that loads the result register; a release
// reads one bitmap row and clears the bit if it was set; an allocate visits k 32-bit bitmap
// rows from the cursor (1 to rows + 1), each row costing one registered read of the pool's
// bitmap store and one pass through the shared free-bit search unit. The result sits in an
// output register, so the next request is accepted while it waits. Rows carry valid flags
// cleared at reset, so there is no clearing pass and requests are taken straight after reset.
module next_fit_id_allocator_top import nfa_pkg::*; #(
  parameter int PROC_FIRST   = DEF_PROC_FIRST,
  parameter int PROC_SLOTS   = DEF_PROC_SLOTS,
  parameter int THREAD_FIRST = DEF_THREAD_FIRST,
  parameter int THREAD_SLOTS = DEF_THREAD_SLOTS
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_stall,
  input  req_word_t req,
  output logic      rsp_valid,
  input  logic      rsp_stall,
  output rsp_word_t rsp
);

  localparam int P_ROWS  = (PROC_SLOTS + WORD_BITS - 1) / WORD_BITS;
  localparam int T_ROWS  = (THREAD_SLOTS + WORD_BITS - 1) / WORD_BITS;
  localparam int P_ROW_W = (P_ROWS > 1) ? $clog2(P_ROWS) : 1;
  localparam int T_ROW_W = (T_ROWS > 1) ? $clog2(T_ROWS) : 1;
  localparam int P_TAIL  = PROC_SLOTS - (P_ROWS - 1) * WORD_BITS;
  localparam int T_TAIL  = THREAD_SLOTS - (T_ROWS - 1) * WORD_BITS;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_RD     = 3'd1;
  localparam logic [2:0] S_EV     = 3'd2;
  localparam logic [2:0] S_REL_RD = 3'd3;
  localparam logic [2:0] S_REL_EV = 3'd4;
  localparam logic [2:0] S_PUSH   = 3'd5;

  logic [2:0]           state;
  req_word_t            op;
  logic [ROW_W_MAX-1:0] row;
  logic [WORD_W-1:0]    lo;
  rsp_word_t            res;
  logic [CNT_W-1:0]     p_count;
  logic [CNT_W-1:0]     t_count;
  logic [OFS_W-1:0]     p_cursor;
  logic [OFS_W-1:0]     t_cursor;

  logic [WORD_BITS-1:0] p_rd_word;
  logic [WORD_BITS-1:0] t_rd_word;
  logic [WORD_BITS-1:0] rd_word;
  logic [WORD_BITS-1:0] scan_word;
  logic [ROW_W_MAX-1:0] last_row;
  logic [WORD_W:0]      tail;
  logic                 ffz_found;
  logic [WORD_W-1:0]    ffz_pos;
  logic [OFS_W-1:0]     found_off;
  logic [OFS_W-1:0]     cursor_next;
  logic [15:0]          granted_next;
  logic                 rd_en;
  logic                 wr_en;
  logic [WORD_BITS-1:0] wr_word;
  logic                 rel_hit;

  logic [16:0]          p_diff;
  logic [16:0]          t_diff;
  logic                 in_proc;
  logic                 in_thread;
  logic [1:0]           class_next;

  logic [CNT_W-1:0]     sel_count;
  logic [CNT_W-1:0]     sel_slots;
  logic [OFS_W-1:0]     sel_cursor;
  logic [16:0]          sel_diff;
  logic                 sel_in;

  assign req_stall = (state != S_IDLE);

  assign p_diff    = {1'b0, req.ident} - 17'(PROC_FIRST);
  assign t_diff    = {1'b0, req.ident} - 17'(THREAD_FIRST);
  assign in_proc   = !p_diff[16] && (p_diff < 17'(PROC_SLOTS));
  assign in_thread = !t_diff[16] && (t_diff < 17'(THREAD_SLOTS));
  assign class_next = in_proc ? CLASS_PROC : (in_thread ? CLASS_THREAD : CLASS_INVALID);

  always_comb begin
    if (req.pool == POOL_THREAD) begin
      sel_count  = t_count;
      sel_slots  = CNT_W'(THREAD_SLOTS);
      sel_cursor = t_cursor;
      sel_diff   = t_diff;
      sel_in     = in_thread;
    end else begin
      sel_count  = p_count;
      sel_slots  = CNT_W'(PROC_SLOTS);
      sel_cursor = p_cursor;
      sel_diff   = p_diff;
      sel_in     = in_proc;
    end
  end

  always_comb begin
    if (op.pool == POOL_THREAD) begin
      rd_word  = t_rd_word;
      last_row = ROW_W_MAX'(T_ROWS - 1);
      tail     = (WORD_W+1)'(T_TAIL);
    end else begin
      rd_word  = p_rd_word;
      last_row = ROW_W_MAX'(P_ROWS - 1);
      tail     = (WORD_W+1)'(P_TAIL);
    end
  end

  // Bits past the end of the pool in its last row count as used.
  assign scan_word = rd_word | ((row == last_row) ? ~low_mask(tail) : '0);

  nfa_ffz u_ffz (
    .word  (scan_word),
    .from  (lo),
    .found (ffz_found),
    .pos   (ffz_pos)
  );

  assign found_off = {row, ffz_pos};
  assign rel_hit   = rd_word[lo];

  always_comb begin
    if (op.pool == POOL_THREAD) begin
      cursor_next  = (found_off == OFS_W'(THREAD_SLOTS - 1)) ? '0 : found_off + 1'b1;
      granted_next = 16'(THREAD_FIRST) + 16'(found_off);
    end else begin
      cursor_next  = (found_off == OFS_W'(PROC_SLOTS - 1)) ? '0 : found_off + 1'b1;
      granted_next = 16'(PROC_FIRST) + 16'(found_off);
    end
  end

  always_comb begin
    rd_en   = (state == S_RD) || (state == S_REL_RD);
    wr_en   = 1'b0;
    wr_word = rd_word;
    if (state == S_EV && ffz_found) begin
      wr_en   = 1'b1;
      wr_word = rd_word | (WORD_BITS'(1) << ffz_pos);
    end else if (state == S_REL_EV && rel_hit) begin
      wr_en   = 1'b1;
      wr_word = rd_word & ~(WORD_BITS'(1) << lo);
    end
  end

  nfa_bitmap #(.ROWS(P_ROWS)) u_proc_map (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (rd_en && op.pool == POOL_PROC),
    .rd_row  (row[P_ROW_W-1:0]),
    .rd_word (p_rd_word),
    .wr_en   (wr_en && op.pool == POOL_PROC),
    .wr_row  (row[P_ROW_W-1:0]),
    .wr_word (wr_word)
  );

  nfa_bitmap #(.ROWS(T_ROWS)) u_thread_map (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (rd_en && op.pool == POOL_THREAD),
    .rd_row  (row[T_ROW_W-1:0]),
    .rd_word (t_rd_word),
    .wr_en   (wr_en && op.pool == POOL_THREAD),
    .wr_row  (row[T_ROW_W-1:0]),
    .wr_word (wr_word)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
      p_count   <= '0;
      t_count   <= '0;
      p_cursor  <= '0;
      t_cursor  <= '0;
    end else begin
      if (state == S_PUSH && (!rsp_valid || !rsp_stall)) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req_valid) begin
            op <= req;
            case (req.kind)
              KIND_ALLOC: begin
                if (sel_count >= sel_slots) begin
                  res   <= {16'd0, 1'b1, CLASS_PROC};
                  state <= S_PUSH;
                end else begin
                  res   <= '0;
                  row   <= sel_cursor[OFS_W-1:WORD_W];
                  lo    <= sel_cursor[WORD_W-1:0];
                  state <= S_RD;
                end
              end
              KIND_RELEASE: begin
                res   <= '0;
                row   <= sel_diff[OFS_W-1:WORD_W];
                lo    <= sel_diff[WORD_W-1:0];
                state <= sel_in ? S_REL_RD : S_PUSH;
              end
              KIND_CLASSIFY: begin
                res   <= {16'd0, 1'b0, class_next};
                state <= S_PUSH;
              end
              default: begin
                res   <= '0;
                state <= S_PUSH;
              end
            endcase
          end
        end
        S_RD: begin
          state <= S_EV;
        end
        S_EV: begin
          if (ffz_found) begin
            res.granted_id <= granted_next;
            if (op.pool == POOL_THREAD) begin
              t_count  <= t_count + 1'b1;
              t_cursor <= cursor_next;
            end else begin
              p_count  <= p_count + 1'b1;
              p_cursor <= cursor_next;
            end
            state <= S_PUSH;
          end else begin
            row   <= (row == last_row) ? '0 : row + 1'b1;
            lo    <= '0;
            state <= S_RD;
          end
        end
        S_REL_RD: begin
          state <= S_REL_EV;
        end
        S_REL_EV: begin
          if (rel_hit) begin
            if (op.pool == POOL_THREAD) begin
              t_count <= t_count - 1'b1;
            end else begin
              p_count <= p_count - 1'b1;
            end
          end
          state <= S_PUSH;
        end
        S_PUSH: begin
          if (!rsp_valid || !rsp_stall) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_PUSH && (!rsp_valid || !rsp_stall)) begin
      rsp <= res;
    end
  end

  a_accept_blocks: assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall) |=> req_stall)
    else $error("request accepted while another was still being served");

  a_exhausted_clean: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.exhausted) |-> (rsp.granted_id == 16'd0 && rsp.id_class == CLASS_PROC))
    else $error("exhausted result carries a granted identifier or a class");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    (p_count <= CNT_W'(PROC_SLOTS)) && (t_count <= CNT_W'(THREAD_SLOTS)))
    else $error("live count exceeds pool size");

  a_cursor_bound: assert property (@(posedge clk) disable iff (rst)
    (p_cursor < OFS_W'(PROC_SLOTS)) && (t_cursor < OFS_W'(THREAD_SLOTS)))
    else $error("cursor left its pool range");

endmodule

### bench/testbench.sv
// Self-checking testbench for next_fit_id_allocator_top with its default pool ranges.
// It keeps its own model of both pools and compares every result word with it.
// It depends on nfa_pkg and the allocator RTL only.
module testbench;
  import nfa_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int LIMIT_CYCLES = 1_000_000;
  localparam int PF = DEF_PROC_FIRST;
  localparam int PS = DEF_PROC_SLOTS;
  localparam int TF = DEF_THREAD_FIRST;
  localparam int TS = DEF_THREAD_SLOTS;

  typedef struct {
    req_word_t word;
    bit        drain;
  } queued_req_t;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      req_valid = 1'b0;
  logic      req_stall;
  req_word_t req = '0;
  logic      rsp_valid;
  logic      rsp_stall = 1'b0;
  rsp_word_t rsp;

  queued_req_t request_words[$];
  rsp_word_t   pending_outcomes[$];

  // Model of both pools, indexed by the pool bit.
  bit used_map[2][MAX_SLOTS];
  int pool_first[2] = '{PF, TF};
  int pool_slots[2] = '{PS, TS};
  int live_count[2] = '{0, 0};
  int cursor[2] = '{PF & 16'hFFFF, TF & 16'hFFFF};

  int allocs_queued[2] = '{0, 0};
  int words_total = 0;
  int words_accepted = 0;
  int words_sent = 0;
  int results_seen = 0;
  int mismatches = 0;
  int cycles = 0;
  int gap_left = 0;
  int stall_left = 0;
  bit req_taken = 1'b0;
  bit rsp_taken = 1'b0;
  bit rsp_held = 1'b0;

  next_fit_id_allocator_top #(
    .PROC_FIRST  (PF),
    .PROC_SLOTS  (PS),
    .THREAD_FIRST(TF),
    .THREAD_SLOTS(TS)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp      (rsp)
  );

  always #5 clk = ~clk;

  function automatic rsp_word_t allocator_outcome(input req_word_t w);
    rsp_word_t r;
    int p, id, start, off;
    bit found;
    r = '0;
    p = int'(w.pool);
    id = int'(w.ident);
    found = 1'b0;
    case (w.kind)
      KIND_ALLOC: begin
        if (live_count[p] < pool_slots[p]) begin
          start = (cursor[p] - pool_first[p]) & 16'hFFFF;
          if (start >= pool_slots[p]) start = 0;
          for (int i = 0; i < pool_slots[p] && !found; i++) begin
            off = start + i;
            if (off >= pool_slots[p]) off -= pool_slots[p];
            if (!used_map[p][off]) begin
              found = 1'b1;
              used_map[p][off] = 1'b1;
              live_count[p]++;
              cursor[p] = (pool_first[p] + ((off + 1 < pool_slots[p]) ? off + 1 : 0))
                          & 16'hFFFF;
              r.granted_id = 16'(pool_first[p] + off);
            end
          end
        end
        r.exhausted = !found;
      end
      KIND_RELEASE: begin
        off = id - pool_first[p];
        if (id >= pool_first[p] && off < pool_slots[p]) begin
          if (used_map[p][off]) begin
            used_map[p][off] = 1'b0;
            if (live_count[p] > 0) live_count[p]--;
          end
        end
      end
      KIND_CLASSIFY: begin
        if (id >= PF && id - PF < PS) r.id_class = CLASS_PROC;
        else if (id >= TF && id - TF < TS) r.id_class = CLASS_THREAD;
        else r.id_class = CLASS_INVALID;
      end
      default: r = '0;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(input string field, input int got, input int want);
    $display("mismatch at cycle %0d, result %0d: %s is %0d, should be %0d",
             cycles, results_seen, field, got, want);
    mismatches++;
  endtask

  task automatic add_word(input logic [1:0] kind, input logic pool, input logic [15:0] ident,
                          input bit drain);
    queued_req_t q;
    q.word.kind = kind;
    q.word.pool = pool;
    q.word.ident = ident;
    q.drain = drain;
    request_words.push_back(q);
    if (kind == KIND_ALLOC) allocs_queued[pool]++;
  endtask

  // Releases aim at the part of the range that has been handed out so far.
  function automatic logic [15:0] release_target(input int p);
    int top;
    top = allocs_queued[p] - 1;
    if (top < 0) top = 0;
    if (top > pool_slots[p] - 1) top = pool_slots[p] - 1;
    return 16'(pool_first[p] + $urandom_range(0, top));
  endfunction

  task automatic add_noise();
    case ($urandom_range(0, 4))
      0: add_word(KIND_CLASSIFY, 1'($urandom), 16'($urandom), 1'b0);
      1: begin
        case ($urandom_range(0, 2))
          0: add_word(KIND_CLASSIFY, 1'($urandom), 16'($urandom_range(PS - 2, PS + 1)), 1'b0);
          1: add_word(KIND_CLASSIFY, 1'($urandom),
                      16'($urandom_range(TF + TS - 2, TF + TS + 1)), 1'b0);
          default: add_word(KIND_CLASSIFY, 1'($urandom),
                            16'($urandom_range(65532, 65535)), 1'b0);
        endcase
      end
      2: add_word(KIND_RELEASE, 1'($urandom), 16'($urandom), 1'b0);
      3: add_word(KIND_UNUSED, 1'($urandom), 16'($urandom), 1'b0);
      default: add_word(KIND_ALLOC, 1'($urandom), 16'($urandom), 1'b0);
    endcase
  endtask

  initial begin
    int r;
    add_word(KIND_CLASSIFY, POOL_PROC, 16'(PF), 1'b0);
    add_word(KIND_CLASSIFY, POOL_PROC, 16'(PF + PS - 1), 1'b0);
    add_word(KIND_CLASSIFY, POOL_THREAD, 16'(TF), 1'b0);
    add_word(KIND_CLASSIFY, POOL_PROC, 16'(TF + TS - 1), 1'b0);
    add_word(KIND_CLASSIFY, POOL_THREAD, 16'(TF + TS), 1'b0);
    add_word(KIND_CLASSIFY, POOL_PROC, 16'hFFFF, 1'b0);
    add_word(KIND_ALLOC, POOL_PROC, 16'hFFFF, 1'b0);
    add_word(KIND_ALLOC, POOL_PROC, 16'h0000, 1'b0);
    add_word(KIND_ALLOC, POOL_THREAD, 16'hA5A5, 1'b0);
    add_word(KIND_RELEASE, POOL_PROC, 16'(PF), 1'b0);
    add_word(KIND_RELEASE, POOL_PROC, 16'(PF), 1'b0);
    add_word(KIND_RELEASE, POOL_PROC, 16'hFFFF, 1'b0);
    add_word(KIND_RELEASE, POOL_THREAD, 16'(TF - 1), 1'b0);
    add_word(KIND_RELEASE, POOL_THREAD, 16'(TF + TS), 1'b0);
    add_word(KIND_RELEASE, POOL_PROC, 16'(PF + PS), 1'b0);
    add_word(KIND_UNUSED, POOL_THREAD, 16'hFFFF, 1'b0);
    add_word(KIND_ALLOC, POOL_PROC, 16'h5A5A, 1'b0);
    add_word(KIND_ALLOC, POOL_THREAD, 16'h0000, 1'b0);
    add_word(KIND_RELEASE, POOL_THREAD, 16'(TF), 1'b0);
    add_word(KIND_ALLOC, POOL_THREAD, 16'hFFFF, 1'b0);
    add_word(KIND_UNUSED, POOL_PROC, 16'h0000, 1'b0);
    add_word(KIND_CLASSIFY, POOL_THREAD, 16'(TF + 44), 1'b0);

    // Fill the process pool well past exhaustion.
    repeat (300) begin
      if ($urandom_range(0, 9) < 9) add_word(KIND_ALLOC, POOL_PROC, 16'($urandom), 1'b0);
      else add_noise();
    end
    add_word(KIND_RELEASE, POOL_PROC, release_target(0), 1'b1);
    repeat (120) begin
      r = $urandom_range(0, 19);
      if (r < 9) add_word(KIND_RELEASE, POOL_PROC, release_target(0), 1'b0);
      else if (r < 18) add_word(KIND_ALLOC, POOL_PROC, 16'($urandom), 1'b0);
      else add_noise();
    end
    repeat (120) begin
      r = $urandom_range(0, 19);
      if (r < 12) add_word(KIND_ALLOC, POOL_THREAD, 16'($urandom), 1'b0);
      else if (r < 17) add_word(KIND_RELEASE, POOL_THREAD, release_target(1), 1'b0);
      else add_noise();
    end
    // A long run of thread allocations with the odd release among them.
    add_word(KIND_ALLOC, POOL_THREAD, 16'($urandom), 1'b1);
    repeat (100) begin
      if ($urandom_range(0, 19) < 19) add_word(KIND_ALLOC, POOL_THREAD, 16'($urandom), 1'b0);
      else add_word(KIND_RELEASE, POOL_THREAD, release_target(1), 1'b0);
    end
    add_word(KIND_RELEASE, POOL_THREAD, release_target(1), 1'b1);
    repeat (40) begin
      r = $urandom_range(0, 19);
      if (r < 9) add_word(KIND_RELEASE, 1'($urandom), release_target(r & 1), 1'b0);
      else if (r < 18) add_word(KIND_ALLOC, 1'($urandom), 16'($urandom), 1'b0);
      else add_noise();
    end
    words_total = request_words.size();

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    do @(negedge clk); while (words_accepted != words_total || pending_outcomes.size() != 0);
    repeat (12) @(negedge clk);
    if (mismatches == 0 && pending_outcomes.size() == 0) $display("PASSED: all results match");
    else $display("FAILED: results differ");
    $finish;
  end

  always @(negedge clk) begin : drive_requests
    queued_req_t q;
    logic next_valid;
    req_word_t next_word;
    next_valid = req_valid;
    next_word = req;
    if (!rst && !(req_valid && !req_taken)) begin
      next_valid = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
      end else if (request_words.size() > 0 &&
                   (!request_words[0].drain || pending_outcomes.size() == 0)) begin
        q = request_words.pop_front();
        next_word = q.word;
        next_valid = 1'b1;
        words_sent++;
        gap_left = ((words_sent / 64) % 3 != 0) ? $urandom_range(0, 3) : 0;
      end
    end
    req_valid <= next_valid;
    req <= next_word;
  end

  always @(negedge clk) begin : drive_stall
    int n;
    n = stall_left;
    if (rsp_taken) n = ((results_seen / 50) % 3 != 2) ? $urandom_range(0, 3) : 0;
    else if (rsp_held && n > 0) n--;
    stall_left <= n;
    rsp_stall <= (n > 0);
  end

  always @(posedge clk) begin : check_results
    rsp_word_t want;
    cycles++;
    if (cycles >= LIMIT_CYCLES) begin
      $display("FAILED: results differ");
      $finish;
    end else if (rst) begin
      req_taken <= 1'b0;
      rsp_taken <= 1'b0;
      rsp_held <= 1'b0;
    end else begin
      req_taken <= req_valid && !req_stall;
      rsp_taken <= rsp_valid && !rsp_stall;
      rsp_held <= rsp_valid && rsp_stall;
      if (rsp_valid && !rsp_stall) begin
        results_seen++;
        if (pending_outcomes.size() == 0) begin
          report_mismatch("result word with none outstanding", 1, 0);
        end else begin
          want = pending_outcomes.pop_front();
          if (rsp.granted_id !== want.granted_id)
            report_mismatch("granted_id", rsp.granted_id, want.granted_id);
          if (rsp.exhausted !== want.exhausted)
            report_mismatch("exhausted", rsp.exhausted, want.exhausted);
          if (rsp.id_class !== want.id_class)
            report_mismatch("id_class", rsp.id_class, want.id_class);
        end
      end
      if (req_valid && !req_stall) begin
        pending_outcomes.push_back(allocator_outcome(req));
        words_accepted++;
      end
    end
  end

endmodule
